@@ rtl/lqrs_pkg.sv @@
// Package for the linear/quadratic root solver: widths, item types and the
// quotient finishing function. No dependencies.
`default_nettype none

package lqrs_pkg;

   // Coefficient format and tolerance register
   localparam int FRAC_BITS      = 16;
   localparam int COEF_W         = 32;
   localparam int TOL_W          = 16;
   localparam int TOL_RESET      = 4;
   localparam int TOL_SCALE_BITS = 32;

   // Derived datapath widths
   localparam int LIN_W     = COEF_W + TOL_SCALE_BITS;
   localparam int PROD_W    = 2 * COEF_W;
   localparam int TMC_W     = TOL_W + COEF_W;
   localparam int P4T_W     = PROD_W + TOL_W;
   localparam int CMP_W     = PROD_W + TOL_SCALE_BITS + 1;
   localparam int D_W       = PROD_W + 2;
   localparam int REM_W     = D_W + 2;
   localparam int ROOT_BITS = D_W / 2 + 1;
   localparam int DEN_W     = ROOT_BITS;
   localparam int NUM_W     = DEN_W + FRAC_BITS + 1;
   localparam int QUO_BITS  = COEF_W + 1;

   localparam logic [1:0] DEG_LINEAR = 2'd1;
   localparam logic [1:0] DEG_QUAD   = 2'd2;

   localparam logic [COEF_W-1:0] MAX_POS = {1'b0, {(COEF_W - 1){1'b1}}};
   localparam logic [COEF_W-1:0] MIN_NEG = {1'b1, {(COEF_W - 1){1'b0}}};

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_LIN,
      KIND_DBL,
      KIND_TWO
   } kind_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_const;
      logic signed [COEF_W-1:0] coef_linear;
      logic signed [COEF_W-1:0] coef_square;
      logic [1:0]               degree;
   } req_type;

   typedef struct packed {
      logic [1:0]               root_count;
      logic signed [COEF_W-1:0] first_root;
      logic signed [COEF_W-1:0] second_root;
      logic                     saturated;
   } rsp_type;

   // Item as it travels through the square-root stages
   typedef struct packed {
      kind_type            kind;
      logic                na;
      logic                nb;
      logic                nc;
      logic [COEF_W-1:0]   ma;
      logic [COEF_W-1:0]   mb;
      logic [COEF_W-1:0]   mc;
      logic [REM_W-1:0]    rem;
      logic [ROOT_BITS-1:0] root;
   } sq_type;

   // One divider lane
   typedef struct packed {
      logic                neg;
      logic                zden;
      logic                znum;
      logic                ovf;
      logic [NUM_W-1:0]    rem;
      logic [DEN_W-1:0]    den;
      logic [QUO_BITS-1:0] quo;
   } lane_type;

   typedef struct packed {
      kind_type kind;
      logic     qneg;
      lane_type lane_a;
      lane_type lane_c;
   } dv_type;

   typedef struct packed {
      logic [COEF_W-1:0] value;
      logic              sat;
   } fin_type;

   // Apply sign and clamp to a rounded quotient
   function automatic fin_type finish(lane_type l);
      fin_type f;
      f.sat   = 1'b0;
      f.value = '0;
      if (l.zden) begin
         f.sat   = 1'b1;
         f.value = l.znum ? '0 : (l.neg ? MIN_NEG : MAX_POS);
      end else if (l.ovf) begin
         f.sat   = 1'b1;
         f.value = l.neg ? MIN_NEG : MAX_POS;
      end else if (l.neg) begin
         if (l.quo > {1'b0, MIN_NEG}) begin
            f.sat   = 1'b1;
            f.value = MIN_NEG;
         end else begin
            f.value = '0 - l.quo[COEF_W-1:0];
         end
      end else begin
         if (l.quo > {1'b0, MAX_POS}) begin
            f.sat   = 1'b1;
            f.value = MAX_POS;
         end else begin
            f.value = l.quo[COEF_W-1:0];
         end
      end
      return f;
   endfunction

endpackage

`default_nettype wire

@@ rtl/lqrs_channels.sv @@
// Handshake channels of the root solver: request, response and register write.
// Depends on lqrs_pkg.
`default_nettype none

interface lqrs_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [lqrs_pkg::COEF_W-1:0] coef_const;
   logic signed [lqrs_pkg::COEF_W-1:0] coef_linear;
   logic signed [lqrs_pkg::COEF_W-1:0] coef_square;
   logic [1:0]                        degree;
   modport source (output valid, coef_const, coef_linear, coef_square, degree,
                   input ready);
   modport sink   (input valid, coef_const, coef_linear, coef_square, degree,
                   output ready);
endinterface

interface lqrs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        root_count;
   logic signed [lqrs_pkg::COEF_W-1:0] first_root;
   logic signed [lqrs_pkg::COEF_W-1:0] second_root;
   logic                              saturated;
   modport source (output valid, root_count, first_root, second_root, saturated,
                   input ready);
   modport sink   (input valid, root_count, first_root, second_root, saturated,
                   output ready);
endinterface

interface lqrs_csr_if;
   logic                         valid;
   logic                         ready;
   logic [lqrs_pkg::TOL_W-1:0]   tol_word;
   modport source (output valid, tol_word, input ready);
   modport sink   (input valid, tol_word, output ready);
endinterface

`default_nettype wire

@@ rtl/lqrs_front.sv @@
// Front end: magnitudes, products, tolerance compares and discriminant.
// Four register stages. Depends on lqrs_pkg.
`default_nettype none

module lqrs_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic                        in_valid,
   input  wire lqrs_pkg::req_type           in_item,
   input  wire logic [lqrs_pkg::TOL_W-1:0]  tol,
   output logic                             out_valid,
   output lqrs_pkg::sq_type                 out_item
);

   typedef struct packed {
      logic [1:0]                  degree;
      logic                        na;
      logic                        nb;
      logic                        nc;
      logic [lqrs_pkg::COEF_W-1:0] ma;
      logic [lqrs_pkg::COEF_W-1:0] mb;
      logic [lqrs_pkg::COEF_W-1:0] mc;
   } s1_type;

   typedef struct packed {
      s1_type                      base;
      logic [lqrs_pkg::PROD_W-1:0] bsq;
      logic [lqrs_pkg::PROD_W-1:0] p4;
      logic [lqrs_pkg::TMC_W-1:0]  tmc;
   } s2_type;

   typedef struct packed {
      s1_type                      base;
      logic [lqrs_pkg::PROD_W-1:0] bsq;
      logic [lqrs_pkg::PROD_W-1:0] p4;
      logic [lqrs_pkg::P4T_W-1:0]  p4t;
      logic                        lin_ok;
   } s3_type;

   function automatic logic [lqrs_pkg::COEF_W-1:0] magnitude(
      logic [lqrs_pkg::COEF_W-1:0] v);
      return v[lqrs_pkg::COEF_W-1] ? ('0 - v) : v;
   endfunction

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   lqrs_pkg::sq_type s4_in, s4_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   logic [lqrs_pkg::CMP_W-1:0] lhs, p4s, p4t_e;
   logic [lqrs_pkg::D_W-1:0]   bsq_e, four_p4;
   logic                       acpos, none_q, dbl_q;

   // Split signs from magnitudes
   always_comb begin
      s1_in.degree = in_item.degree;
      s1_in.na     = in_item.coef_square[lqrs_pkg::COEF_W-1];
      s1_in.nb     = in_item.coef_linear[lqrs_pkg::COEF_W-1];
      s1_in.nc     = in_item.coef_const[lqrs_pkg::COEF_W-1];
      s1_in.ma     = magnitude(in_item.coef_square);
      s1_in.mb     = magnitude(in_item.coef_linear);
      s1_in.mc     = magnitude(in_item.coef_const);
   end

   // b^2, a*c and tol*|c|
   always_comb begin
      s2_in.base = s1_ff;
      s2_in.bsq  = s1_ff.mb * s1_ff.mb;
      s2_in.p4   = s1_ff.ma * s1_ff.mc;
      s2_in.tmc  = s1_ff.mc * tol;
   end

   // a*c*tol and the linear tolerance test
   always_comb begin
      s3_in.base   = s2_ff.base;
      s3_in.bsq    = s2_ff.bsq;
      s3_in.p4     = s2_ff.p4;
      s3_in.p4t    = s2_ff.p4 * tol;
      s3_in.lin_ok = {s2_ff.base.mb, {lqrs_pkg::TOL_SCALE_BITS{1'b0}}}
                     >= lqrs_pkg::LIN_W'(s2_ff.tmc);
   end

   // Discriminant band tests, case selection and discriminant
   always_comb begin
      lhs     = lqrs_pkg::CMP_W'(s3_ff.bsq) << (lqrs_pkg::TOL_SCALE_BITS - 2);
      p4s     = lqrs_pkg::CMP_W'(s3_ff.p4) << lqrs_pkg::TOL_SCALE_BITS;
      p4t_e   = lqrs_pkg::CMP_W'(s3_ff.p4t);
      none_q  = (lhs + p4t_e) < p4s;
      dbl_q   = lhs < (p4s + p4t_e);
      acpos   = (s3_ff.base.ma != '0) && (s3_ff.base.mc != '0)
                && (s3_ff.base.na == s3_ff.base.nc);
      bsq_e   = lqrs_pkg::D_W'(s3_ff.bsq);
      four_p4 = {s3_ff.p4, 2'b00};

      s4_in.na   = s3_ff.base.na;
      s4_in.nb   = s3_ff.base.nb;
      s4_in.nc   = s3_ff.base.nc;
      s4_in.ma   = s3_ff.base.ma;
      s4_in.mb   = s3_ff.base.mb;
      s4_in.mc   = s3_ff.base.mc;
      s4_in.root = '0;
      s4_in.rem  = lqrs_pkg::REM_W'(acpos ? (bsq_e - four_p4) : (bsq_e + four_p4));

      unique case (s3_ff.base.degree)
         lqrs_pkg::DEG_LINEAR: begin
            s4_in.kind = s3_ff.lin_ok ? lqrs_pkg::KIND_LIN : lqrs_pkg::KIND_NONE;
         end
         lqrs_pkg::DEG_QUAD: begin
            if (acpos && none_q) begin
               s4_in.kind = lqrs_pkg::KIND_NONE;
            end else if (acpos && dbl_q) begin
               s4_in.kind = lqrs_pkg::KIND_DBL;
            end else begin
               s4_in.kind = lqrs_pkg::KIND_TWO;
            end
         end
         default: begin
            s4_in.kind = lqrs_pkg::KIND_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_item  = s4_ff;

endmodule

`default_nettype wire

@@ rtl/lqrs_sqrt.sv @@
// Pipelined floor square root of the discriminant, one root bit per stage.
// Depends on lqrs_pkg.
`default_nettype none

module lqrs_sqrt (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic             in_valid,
   input  wire lqrs_pkg::sq_type in_item,
   output logic                  out_valid,
   output lqrs_pkg::sq_type      out_item
);

   lqrs_pkg::sq_type st_in  [lqrs_pkg::ROOT_BITS];
   lqrs_pkg::sq_type st_ff  [lqrs_pkg::ROOT_BITS];
   lqrs_pkg::sq_type cur    [lqrs_pkg::ROOT_BITS];
   logic             cur_v  [lqrs_pkg::ROOT_BITS];
   logic             vld_ff [lqrs_pkg::ROOT_BITS];

   for (genvar i = 0; i < lqrs_pkg::ROOT_BITS; i++) begin : g_step
      localparam int B = lqrs_pkg::ROOT_BITS - 1 - i;
      logic [lqrs_pkg::REM_W-1:0] trial;

      if (i == 0) begin : g_first
         assign cur[i]   = in_item;
         assign cur_v[i] = in_valid;
      end else begin : g_next
         assign cur[i]   = st_ff[i-1];
         assign cur_v[i] = vld_ff[i-1];
      end

      // Keep rem = d - root^2; try setting root bit B
      always_comb begin
         trial = (lqrs_pkg::REM_W'(cur[i].root) << (B + 1))
                 + (lqrs_pkg::REM_W'(1) << (2 * B));
         st_in[i] = cur[i];
         if (cur[i].rem >= trial) begin
            st_in[i].rem     = cur[i].rem - trial;
            st_in[i].root[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= cur_v[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign out_valid = vld_ff[lqrs_pkg::ROOT_BITS-1];
   assign out_item  = st_ff[lqrs_pkg::ROOT_BITS-1];

endmodule

`default_nettype wire

@@ rtl/lqrs_div.sv @@
// Two-lane pipelined rounding divider: operand selection, rounding offset and
// range check, then one quotient bit per stage. Depends on lqrs_pkg.
`default_nettype none

module lqrs_div (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic             in_valid,
   input  wire lqrs_pkg::sq_type in_item,
   output logic                  out_valid,
   output lqrs_pkg::dv_type      out_item
);

   localparam int NSTEP = lqrs_pkg::QUO_BITS;

   function automatic lqrs_pkg::lane_type load_lane(
      logic neg, logic [lqrs_pkg::NUM_W-1:0] num, logic [lqrs_pkg::DEN_W-1:0] den);
      lqrs_pkg::lane_type l;
      l.neg  = neg;
      l.rem  = num;
      l.den  = den;
      l.znum = (num == '0);
      l.zden = (den == '0);
      l.ovf  = 1'b0;
      l.quo  = '0;
      return l;
   endfunction

   function automatic lqrs_pkg::lane_type round_lane(lqrs_pkg::lane_type l);
      lqrs_pkg::lane_type r;
      r     = l;
      r.rem = l.rem + lqrs_pkg::NUM_W'(l.den >> 1);
      r.ovf = (r.rem >> lqrs_pkg::QUO_BITS) >= lqrs_pkg::NUM_W'(l.den);
      return r;
   endfunction

   function automatic lqrs_pkg::lane_type step_lane(lqrs_pkg::lane_type l, int k);
      lqrs_pkg::lane_type r;
      logic [lqrs_pkg::NUM_W-1:0] den_e;
      r     = l;
      den_e = lqrs_pkg::NUM_W'(l.den);
      if ((l.rem >> k) >= den_e) begin
         r.rem    = l.rem - (den_e << k);
         r.quo[k] = 1'b1;
      end
      return r;
   endfunction

   lqrs_pkg::dv_type d0_in, d0_ff, d1_in, d1_ff;
   logic             v0_ff, v1_ff;
   logic [lqrs_pkg::DEN_W-1:0] mq;
   logic [lqrs_pkg::DEN_W-1:0] ma2;
   logic                       qneg;

   lqrs_pkg::dv_type bq_in  [NSTEP];
   lqrs_pkg::dv_type bq_ff  [NSTEP];
   lqrs_pkg::dv_type cur    [NSTEP];
   logic             cur_v  [NSTEP];
   logic             bv_ff  [NSTEP];

   // Pick dividend and divisor for each lane
   always_comb begin
      mq   = lqrs_pkg::DEN_W'(in_item.mb) + in_item.root;
      ma2  = lqrs_pkg::DEN_W'({in_item.ma, 1'b0});
      qneg = (in_item.mb != '0) && !in_item.nb;

      d0_in.kind   = in_item.kind;
      d0_in.qneg   = qneg;
      d0_in.lane_c = load_lane(in_item.nc != qneg,
                               lqrs_pkg::NUM_W'(in_item.mc) << (lqrs_pkg::FRAC_BITS + 1),
                               mq);
      unique case (in_item.kind)
         lqrs_pkg::KIND_LIN: begin
            d0_in.lane_a = load_lane(in_item.nc == in_item.nb,
                                     lqrs_pkg::NUM_W'(in_item.mc) << lqrs_pkg::FRAC_BITS,
                                     lqrs_pkg::DEN_W'(in_item.mb));
         end
         lqrs_pkg::KIND_DBL: begin
            d0_in.lane_a = load_lane(in_item.nb == in_item.na,
                                     lqrs_pkg::NUM_W'(in_item.mb) << lqrs_pkg::FRAC_BITS,
                                     ma2);
         end
         lqrs_pkg::KIND_TWO: begin
            d0_in.lane_a = load_lane(qneg != in_item.na,
                                     lqrs_pkg::NUM_W'(mq) << lqrs_pkg::FRAC_BITS,
                                     ma2);
         end
         default: begin
            d0_in.lane_a = load_lane(1'b0, '0, '0);
         end
      endcase
   end

   always_comb begin
      d1_in        = d0_ff;
      d1_in.lane_a = round_lane(d0_ff.lane_a);
      d1_in.lane_c = round_lane(d0_ff.lane_c);
   end

   for (genvar i = 0; i < NSTEP; i++) begin : g_step
      localparam int K = NSTEP - 1 - i;

      if (i == 0) begin : g_first
         assign cur[i]   = d1_ff;
         assign cur_v[i] = v1_ff;
      end else begin : g_next
         assign cur[i]   = bq_ff[i-1];
         assign cur_v[i] = bv_ff[i-1];
      end

      always_comb begin
         bq_in[i]        = cur[i];
         bq_in[i].lane_a = step_lane(cur[i].lane_a, K);
         bq_in[i].lane_c = step_lane(cur[i].lane_c, K);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            bv_ff[i] <= 1'b0;
         end else if (advance) begin
            bv_ff[i] <= cur_v[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            bq_ff[i] <= bq_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d0_ff <= d0_in;
         d1_ff <= d1_in;
      end
   end

   assign out_valid = bv_ff[NSTEP-1];
   assign out_item  = bq_ff[NSTEP-1];

endmodule

`default_nettype wire

@@ rtl/linear_quadratic_root_solver_core.sv @@
// Real roots of c1*x + c0 or c2*x^2 + c1*x + c0 with signed Q16.16
// coefficients, using a relative tolerance to tell no, double and two roots
// apart. The pipeline takes one item every clock cycle and passes it through
// 4 front-end stages (products and tolerance compares), 34 square-root stages
// (one root bit each), 2 divider set-up stages, 33 divider stages (one
// quotient bit each, two lanes side by side) and the output
// register. While a result waits at the output
// the whole pipeline holds, so a full pipeline accepts a new item in the same
// cycle as the waiting one is taken. The tolerance register is written
// through the csr channel, which is always ready; write it only while no item
// is in flight. Roots are rounded to nearest, ties away from zero, and
// clamped to 32 bits; saturated flags a clamp or a zero divisor.
// Depends on lqrs_pkg, lqrs_channels, lqrs_front, lqrs_sqrt and lqrs_div.
`default_nettype none

module linear_quadratic_root_solver_core (
   input wire logic  clock,
   input wire logic  reset,
   lqrs_req_if.sink  req_if,
   lqrs_rsp_if.source rsp_if,
   lqrs_csr_if.sink  csr_if
);

   // Pipeline moves whenever the output register is free or being taken
   logic advance;

   logic [lqrs_pkg::TOL_W-1:0] tol_ff;

   lqrs_pkg::req_type req_item;
   logic              front_valid, sqrt_valid, div_valid;
   lqrs_pkg::sq_type  front_item, sqrt_item;
   lqrs_pkg::dv_type  div_item;

   lqrs_pkg::fin_type fin_a, fin_c;
   lqrs_pkg::rsp_type rsp_in, rsp_ff;
   logic              rsp_valid_ff;

   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;
   assign csr_if.ready = 1'b1;

   // Tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= lqrs_pkg::TOL_W'(lqrs_pkg::TOL_RESET);
      end else if (csr_if.valid) begin
         tol_ff <= csr_if.tol_word;
      end
   end

   always_comb begin
      req_item.coef_const  = req_if.coef_const;
      req_item.coef_linear = req_if.coef_linear;
      req_item.coef_square = req_if.coef_square;
      req_item.degree      = req_if.degree;
   end

   lqrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_if.valid),
      .in_item   (req_item),
      .tol       (tol_ff),
      .out_valid (front_valid),
      .out_item  (front_item)
   );

   lqrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .out_valid (sqrt_valid),
      .out_item  (sqrt_item)
   );

   lqrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sqrt_valid),
      .in_item   (sqrt_item),
      .out_valid (div_valid),
      .out_item  (div_item)
   );

   // Sign, clamp and order the roots. With b > 0 the root from q/2a comes
   // first; otherwise 2c/q comes first.
   always_comb begin
      fin_a = lqrs_pkg::finish(div_item.lane_a);
      fin_c = lqrs_pkg::finish(div_item.lane_c);
      unique case (div_item.kind)
         lqrs_pkg::KIND_NONE: begin
            rsp_in.root_count  = 2'd0;
            rsp_in.first_root  = '0;
            rsp_in.second_root = '0;
            rsp_in.saturated   = 1'b0;
         end
         lqrs_pkg::KIND_LIN,
         lqrs_pkg::KIND_DBL: begin
            rsp_in.root_count  = 2'd1;
            rsp_in.first_root  = fin_a.value;
            rsp_in.second_root = '0;
            rsp_in.saturated   = fin_a.sat;
         end
         lqrs_pkg::KIND_TWO: begin
            rsp_in.root_count  = 2'd2;
            rsp_in.first_root  = div_item.qneg ? fin_a.value : fin_c.value;
            rsp_in.second_root = div_item.qneg ? fin_c.value : fin_a.value;
            rsp_in.saturated   = fin_a.sat | fin_c.sat;
         end
         default: begin
            rsp_in.root_count  = 2'd0;
            rsp_in.first_root  = '0;
            rsp_in.second_root = '0;
            rsp_in.saturated   = 1'b0;
         end
      endcase
   end

   // Output register: hold the item until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.root_count  = rsp_ff.root_count;
   assign rsp_if.first_root  = rsp_ff.first_root;
   assign rsp_if.second_root = rsp_ff.second_root;
   assign rsp_if.saturated   = rsp_ff.saturated;

endmodule

`default_nettype wire

@@ test/tb_lqrs_channels.sv @@
// Testbench note: the channel interfaces come from the RTL file lqrs_channels.sv.
// This file only holds shared helpers for the testbench; depends on lqrs_pkg.
`timescale 1ns / 100ps

package tb_lqrs_util;

   // Expected result of one item
   typedef struct {
      logic [1:0]                  count;
      logic [lqrs_pkg::COEF_W-1:0] first;
      logic [lqrs_pkg::COEF_W-1:0] second;
      logic                        sat;
   } roots_type;
endpackage

@@ test/tb.sv @@
// Testbench for linear_quadratic_root_solver_core: random and directed coefficient
// sets are driven in bursts, roots are predicted in exact integer arithmetic and
// checked in order. Depends on lqrs_pkg, lqrs_channels and tb_lqrs_util.
`timescale 1ns / 100ps

module tb;

   localparam int LATENCY = 73;
   localparam longint LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lqrs_req_if req_if ();
   lqrs_rsp_if rsp_if ();
   lqrs_csr_if csr_if ();

   linear_quadratic_root_solver_core dut (
      .clock (clock), .reset (reset),
      .req_if (req_if.sink), .rsp_if (rsp_if.source), .csr_if (csr_if.sink)
   );

   always #2 clock = ~clock;

   lqrs_pkg::req_type       pending_items[$];
   tb_lqrs_util::roots_type expected_roots[$];
   logic [15:0] tolerance = 16'(lqrs_pkg::TOL_RESET);
   int errors = 0;
   longint cycle = 0;
   bit hold_sender = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_phase = 0;

   // Rounded quotient with sign, clamp to 32 bits and flag a clamp
   function automatic logic [31:0] round_div(bit neg, logic [127:0] num,
                                             logic [127:0] den, ref bit sat);
      logic [127:0] q;
      if (den == 0) begin
         sat = 1'b1;
         if (num == 0) return '0;
         return neg ? lqrs_pkg::MIN_NEG : lqrs_pkg::MAX_POS;
      end
      q = (num + (den >> 1)) / den;
      if (neg) begin
         if (q > 128'h8000_0000) begin sat = 1'b1; q = 128'h8000_0000; end
         return 32'(-q);
      end
      if (q > 128'h7FFF_FFFF) begin sat = 1'b1; q = 128'h7FFF_FFFF; end
      return q[31:0];
   endfunction

   function automatic logic [127:0] isqrt(logic [127:0] d);
      logic [127:0] r, t;
      r = 0;
      for (int b = 33; b >= 0; b--) begin
         t = r | (128'd1 << b);
         if (t * t <= d) r = t;
      end
      return r;
   endfunction

   function automatic tb_lqrs_util::roots_type solve_roots(lqrs_pkg::req_type it,
                                                           logic [15:0] tol);
      tb_lqrs_util::roots_type res;
      bit sat, nc, nb, na, acpos, qneg, finished;
      logic [127:0] mc, mb, ma, bsq, p4, lhs, d, s, mq, t;
      logic [31:0]  ra, rc;
      sat = 1'b0;
      finished = 1'b0;
      res = '{2'd0, '0, '0, 1'b0};
      t  = 128'(tol);
      nc = it.coef_const[31];  mc = nc ? 128'(-$signed(it.coef_const)) : it.coef_const;
      nb = it.coef_linear[31]; mb = nb ? 128'(-$signed(it.coef_linear)) : it.coef_linear;
      na = it.coef_square[31]; ma = na ? 128'(-$signed(it.coef_square)) : it.coef_square;
      mc &= 128'hFFFF_FFFF; mb &= 128'hFFFF_FFFF; ma &= 128'hFFFF_FFFF;
      if (it.degree == lqrs_pkg::DEG_LINEAR) begin
         if (!((mb << 32) < t * mc)) begin
            res.count = 2'd1;
            res.first = round_div(nc == nb, mc << lqrs_pkg::FRAC_BITS, mb, sat);
         end
      end else if (it.degree == lqrs_pkg::DEG_QUAD) begin
         bsq = mb * mb;
         p4 = ma * mc;
         acpos = ma != 0 && mc != 0 && na == nc;
         if (acpos) begin
            lhs = bsq << 30;
            if (lhs < p4 * ((128'd1 << 32) - t)) begin
               finished = 1'b1;
            end else if (lhs < p4 * ((128'd1 << 32) + t)) begin
               res.count = 2'd1;
               res.first = round_div(nb == na, mb << lqrs_pkg::FRAC_BITS, ma << 1, sat);
               finished = 1'b1;
            end
            d = (bsq - (p4 << 2)) & 128'hFFFF_FFFF_FFFF_FFFF;
         end else begin
            d = bsq + 4 * p4;
         end
         if (!finished) begin
            s = isqrt(d);
            mq = mb + s;
            qneg = (mb != 0) && !nb;
            ra = round_div(qneg != na, mq << lqrs_pkg::FRAC_BITS, ma << 1, sat);
            rc = round_div(nc != qneg, mc << (lqrs_pkg::FRAC_BITS + 1), mq, sat);
            res.count = 2'd2;
            res.first  = qneg ? ra : rc;
            res.second = qneg ? rc : ra;
         end
      end
      res.sat = sat;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle, what, got, want);
      errors++;
   endtask

   function automatic logic [31:0] random_coef();
      case ($urandom_range(0, 5))
         0: return 32'($urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF);
         1: return 32'($signed($urandom_range(0, 64)) - 32);
         2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         3: return 32'($urandom_range(0, 8) << 16) * ($urandom_range(0, 1) ? -1 : 1);
         default: return $urandom;
      endcase
   endfunction

   function automatic lqrs_pkg::req_type make_item(logic [31:0] c0, logic [31:0] c1,
                                                   logic [31:0] c2, logic [1:0] deg);
      lqrs_pkg::req_type it;
      it.coef_const = c0; it.coef_linear = c1; it.coef_square = c2; it.degree = deg;
      return it;
   endfunction

   // Build a quadratic near its double-root boundary: c2*(x - r)^2 scaled
   function automatic lqrs_pkg::req_type near_double();
      int a, r;
      a = $urandom_range(1, 300) * ($urandom_range(0, 1) ? -1 : 1);
      r = $signed($urandom_range(0, 2000)) - 1000;
      return make_item(32'(a * r * r + $signed($urandom_range(0, 2)) - 1),
                       32'(-2 * a * r), 32'(a), lqrs_pkg::DEG_QUAD);
   endfunction

   // Driver: bursts with random gaps
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_if.valid <= 1'b0;
         end else if (pending_items.size() > 0 && !hold_sender) begin
            lqrs_pkg::req_type it;
            it = pending_items.pop_front();
            req_if.valid       <= 1'b1;
            req_if.coef_const  <= it.coef_const;
            req_if.coef_linear <= it.coef_linear;
            req_if.coef_square <= it.coef_square;
            req_if.degree      <= it.degree;
            expected_roots.push_back(solve_roots(it, tolerance));
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Monitor: stall on its own pattern, check each accepted result
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_roots.size() == 0) begin
               report_mismatch("unexpected result", 32'(rsp_if.root_count), '0);
            end else begin
               tb_lqrs_util::roots_type e;
               e = expected_roots.pop_front();
               if (rsp_if.root_count != e.count)
                  report_mismatch("root_count", 32'(rsp_if.root_count), 32'(e.count));
               if (rsp_if.first_root != e.first)
                  report_mismatch("first_root", rsp_if.first_root, e.first);
               if (rsp_if.second_root != e.second)
                  report_mismatch("second_root", rsp_if.second_root, e.second);
               if (rsp_if.saturated != e.sat)
                  report_mismatch("saturated", 32'(rsp_if.saturated), 32'(e.sat));
            end
         end
         stall_phase <= (stall_phase + 1) % 96;
         // run free for a stretch, then stall at random
         rsp_if.ready <= (stall_phase < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_if.valid || expected_roots.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [15:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.tol_word <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      tolerance = value;
   endtask

   // Watchdog
   always @(posedge clock) begin
      if (cycle > LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [15:0] settings[5];
      req_if.valid = 1'b0;
      req_if.coef_const = '0; req_if.coef_linear = '0;
      req_if.coef_square = '0; req_if.degree = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.tol_word = '0;
      settings = '{16'd0, 16'hFFFF, 16'd4, 16'd1000, 16'd4};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, both degrees, ignored degrees, zero divisors
      pending_items.push_back(make_item(32'd0, 32'd0, 32'd0, lqrs_pkg::DEG_LINEAR));
      pending_items.push_back(make_item(32'h0001_0000, 32'd0, 32'd0, lqrs_pkg::DEG_LINEAR));
      pending_items.push_back(make_item(lqrs_pkg::MIN_NEG, 32'd1, 32'd0,
                                        lqrs_pkg::DEG_LINEAR));
      pending_items.push_back(make_item(lqrs_pkg::MAX_POS, lqrs_pkg::MIN_NEG, 32'd5,
                                        lqrs_pkg::DEG_LINEAR));
      pending_items.push_back(make_item(32'hFFFE_0000, 32'h0002_0000, 32'd0,
                                        lqrs_pkg::DEG_LINEAR));
      pending_items.push_back(make_item(32'd5, 32'd7, 32'd9, 2'd0));
      pending_items.push_back(make_item(32'd5, 32'd7, 32'd9, 2'd3));
      pending_items.push_back(make_item(32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
                                        lqrs_pkg::DEG_QUAD));
      pending_items.push_back(make_item(32'h0002_0000, 32'h0001_0000, 32'h0001_0000,
                                        lqrs_pkg::DEG_QUAD));
      pending_items.push_back(make_item(32'hFFFF_0000, 32'd0, 32'h0001_0000,
                                        lqrs_pkg::DEG_QUAD));
      pending_items.push_back(make_item(32'h0001_0000, 32'h0003_0000, 32'd0,
                                        lqrs_pkg::DEG_QUAD));
      pending_items.push_back(make_item(32'd0, 32'd0, 32'd0, lqrs_pkg::DEG_QUAD));
      pending_items.push_back(make_item(lqrs_pkg::MIN_NEG, lqrs_pkg::MIN_NEG,
                                        lqrs_pkg::MIN_NEG, lqrs_pkg::DEG_QUAD));
      pending_items.push_back(make_item(lqrs_pkg::MAX_POS, lqrs_pkg::MAX_POS,
                                        lqrs_pkg::MAX_POS, lqrs_pkg::DEG_QUAD));
      pending_items.push_back(make_item(lqrs_pkg::MIN_NEG, lqrs_pkg::MAX_POS, 32'd1,
                                        lqrs_pkg::DEG_QUAD));
      pending_items.push_back(make_item(32'd1, lqrs_pkg::MIN_NEG, lqrs_pkg::MAX_POS,
                                        lqrs_pkg::DEG_QUAD));
      pending_items.push_back(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        lqrs_pkg::DEG_QUAD));
      wait_drained();

      // Random phases under several tolerance settings
      foreach (settings[p]) begin
         write_tolerance(settings[p]);
         for (int i = 0; i < 400; i++) begin
            case ($urandom_range(0, 9))
               0, 1, 2: pending_items.push_back(make_item(random_coef(), random_coef(),
                                                          random_coef(),
                                                          lqrs_pkg::DEG_LINEAR));
               3, 4: pending_items.push_back(near_double());
               5: pending_items.push_back(make_item($urandom, $urandom, $urandom,
                                                    2'($urandom_range(0, 3))));
               default: pending_items.push_back(make_item(random_coef(), random_coef(),
                                                          random_coef(),
                                                          lqrs_pkg::DEG_QUAD));
            endcase
         end
         if (p == 1) begin
            // hold the sender until everything in flight has come back
            while (pending_items.size() > 200) @(posedge clock);
            hold_sender = 1'b1;
            while (req_if.valid || expected_roots.size() > 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         wait_drained();
      end

      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
